FILE: hw/rtl/lis_length_tracker_assert.svh
// Assertion macros for the longest increasing subsequence length tracker.
// Used by lis_length_tracker; relies on clk_i and rst_ni in the including scope.
`ifndef LIS_LENGTH_TRACKER_ASSERT_SVH
`define LIS_LENGTH_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lis_length_tracker assertion failed");

// Next-cycle implication, checked outside reset.
`define LIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lis_length_tracker assertion failed");

`endif

FILE: hw/rtl/lis_pkg.sv
// Shared constants for the longest increasing subsequence length tracker.
// No dependencies; used by lis_length_tracker.
package lis_pkg;

  localparam int unsigned MAX_LEN     = 1024;
  localparam int unsigned VALUE_WIDTH = 32;
  // Length counter holds 0 .. MAX_LEN; table index holds 0 .. MAX_LEN-1.
  localparam int unsigned LEN_W       = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W      = $clog2(MAX_LEN);

  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [VALUE_WIDTH-1:0] key_t;

endpackage

FILE: hw/rtl/lis_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lis_length_tracker.sv
// Channel  | Handshake                | Payload
// ---------+--------------------------+-----------------------------------
// input    | in_valid_i / in_ready_o  | value_i[31:0], last_i
// output   | out_valid_o / out_ready_i| lis_length_o[10:0], seq_end_o, overflow_o
//
// Each item is accepted in the idle state, then runs the binary search over
// the tails table (ceil(log2(length+1)) steps, up to 11 at a length of 1024),
// one read of the single tails RAM read port per step, and then updates the
// table. A new item is taken only in the idle state, after the last one is done.
// Reset clears the length, the overflow flag and the output valid flag; the tails
// RAM is not cleared, as only entries written in the current sequence are read.
// A stalled output holds the block in its update cycle until the result moves.
// Depends on lis_pkg, lis_ram and lis_length_tracker_assert.svh.
`include "lis_length_tracker_assert.svh"

module lis_length_tracker import lis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] lis_length_o,
  output logic        seq_end_o,
  output logic        overflow_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_q, state_d;
  len_t       length_q, length_d;
  logic       ovf_q, ovf_d;
  logic       out_valid_q, out_valid_d;
  len_t       lo_q, lo_d, hi_q, hi_d;
  addr_t      mid_q, mid_d;
  key_t       key_q;
  logic       last_q;
  len_t       out_len_q;
  logic       out_end_q, out_ovf_q;

  logic       accept;
  logic       fire;
  logic       cmp_lt;
  len_t       lo_n, hi_n, mid_n;
  len_t       len_new;
  logic       ovf_new;
  logic       rd_en, wr_en;
  addr_t      rd_addr;
  key_t       rd_data;

  // Tails are stored with the sign bit inverted, so an unsigned compare orders
  // them as signed values.
  lis_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_LEN)
  ) u_tails (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (lo_q[ADDR_W-1:0]),
    .wdata_i (key_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);

  // One search step: the read issued last cycle returns tails[mid].
  assign cmp_lt = rd_data < key_q;
  assign lo_n   = cmp_lt ? (LEN_W'(mid_q) + LEN_W'(1)) : lo_q;
  assign hi_n   = cmp_lt ? hi_q : LEN_W'(mid_q);
  assign mid_n  = lo_n + ((hi_n - lo_n) >> 1);

  always_comb begin
    state_d     = state_q;
    length_d    = length_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    rd_en       = 1'b0;
    rd_addr     = mid_q;
    wr_en       = 1'b0;
    len_new     = length_q;
    ovf_new     = ovf_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // The update writes back in its own cycle and the next read is issued
    // no earlier than the following cycle, so a read never meets a write in
    // flight to the same entry.
    if (lo_q < length_q) begin
      wr_en = fire;
    end else if (length_q < LEN_W'(MAX_LEN)) begin
      wr_en   = fire;
      len_new = length_q + LEN_W'(1);
    end else begin
      ovf_new = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          lo_d = '0;
          hi_d = length_q;
          if (length_q == '0) begin
            state_d = ST_UPDATE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = length_q[LEN_W-1:1];
            mid_d   = length_q[LEN_W-1:1];
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          rd_en   = 1'b1;
          rd_addr = mid_n[ADDR_W-1:0];
          mid_d   = mid_n[ADDR_W-1:0];
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (fire) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (last_q) begin
            length_d = '0;
            ovf_d    = 1'b0;
          end else begin
            length_d = len_new;
            ovf_d    = ovf_new;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      length_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      length_q    <= length_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    if (accept) begin
      key_q  <= {~value_i[VALUE_WIDTH-1], value_i[VALUE_WIDTH-2:0]};
      last_q <= last_i;
    end
    if (fire) begin
      out_len_q <= len_new;
      out_end_q <= last_q;
      out_ovf_q <= ovf_new;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lis_length_o = out_len_q;
  assign seq_end_o    = out_end_q;
  assign overflow_o   = out_ovf_q;

  `LIS_ASSERT_NOW(a_len_bound, 1'b1, length_q <= LEN_W'(MAX_LEN))
  `LIS_ASSERT_NOW(a_mid_in_range, state_q == ST_SEARCH,
                  (LEN_W'(mid_q) >= lo_q) && (LEN_W'(mid_q) < hi_q))
  `LIS_ASSERT_NOW(a_write_in_update, wr_en, fire && !rd_en)
  `LIS_ASSERT_NEXT(a_busy_after_accept, accept, state_q != ST_IDLE)

endmodule
